>>> design/abq_pkg.sv
`timescale 1ns / 1ps
package abq_pkg;

  localparam int BlockLen = 64;
  localparam int AddrW = 6;
  localparam int CountW = 7;

  // Quantisation mode codes.
  typedef enum logic [1:0] {
    MODE_INT8 = 2'd0,
    MODE_INT4 = 2'd1,
    MODE_INT2 = 2'd2,
    MODE_TERN = 2'd3
  } mode_t;

  // One closed block handed from the front end to the back end.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [16:0] scale;
  } blk_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_PACK
  } back_state_t;

endpackage

>>> design/abq_front.sv
`timescale 1ns / 1ps
module abq_front import abq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [15:0]  sample,
  input  logic                end_of_block,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                mem_we,
  output logic [AddrW-1:0]    mem_addr,
  output logic [15:0]         mem_data,
  output logic                blk_valid,
  output blk_t                blk,
  input  logic                blk_done
);

  logic [CountW-1:0] count;
  logic [16:0] peak;
  logic busy;
  logic [16:0] mag;
  logic [CountW-1:0] count_next;
  logic [16:0] peak_next;
  logic close;

  // A closed block owns the store until the back end finishes it.
  assign in_ready = !busy;
  assign mag = sample[15] ? (17'd0 - {sample[15], sample}) : {1'b0, sample};
  assign count_next = count + 1'b1;
  assign peak_next = (mag > peak) ? mag : peak;
  assign close = end_of_block || (count_next >= CountW'(BlockLen));
  assign mem_we = in_valid && in_ready;
  assign mem_addr = count[AddrW-1:0];
  assign mem_data = sample;
  assign blk_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      peak <= '0;
      busy <= 1'b0;
    end else if (busy) begin
      if (blk_done) busy <= 1'b0;
    end else if (mem_we) begin
      if (close) begin
        blk.count <= count_next;
        blk.scale <= (peak_next == 17'd0) ? 17'd256 : peak_next;
        busy <= 1'b1;
        count <= '0;
        peak <= '0;
      end else begin
        count <= count_next;
        peak <= peak_next;
      end
    end
  end

endmodule

>>> design/abq_back.sv
`timescale 1ns / 1ps
module abq_back import abq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         quant_mode,
  input  logic               mem_we,
  input  logic [AddrW-1:0]   mem_waddr,
  input  logic [15:0]        mem_wdata,
  input  logic               blk_valid,
  input  blk_t               blk,
  output logic               blk_done,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         packed_byte,
  output logic [15:0]        block_scale,
  output logic               last_byte
);

  logic [15:0] store [BlockLen];
  logic [15:0] rdata;
  back_state_t state, state_next;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] rd_idx;
  logic adv;
  logic [7:0] acc;
  logic [3:0] pos;
  logic [4:0] step;
  logic [24:0] rem;
  logic [7:0] quo;
  logic [16:0] mag;
  logic [23:0] numer;
  logic [7:0] lvl;
  logic [25:0] trial;
  logic [7:0] code;
  logic [3:0] width;
  logic [7:0] qmag;
  logic [7:0] acc_new;
  logic [3:0] pos_new;
  logic final_s;
  logic flush;
  mode_t mode;

  assign mode = mode_t'(quant_mode);

  // The read address runs one ahead when a sample is packed, so the next
  // sample is already in the read register during the read cycle.
  assign adv = (state == ST_PACK) && !(flush && out_valid && !out_ready);
  assign rd_idx = adv ? (idx + 1'b1) : idx;

  // Sample store, written by the front end and read by the back end.
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rdata <= store[rd_idx[AddrW-1:0]];
  end

  always_comb begin
    lvl = 8'd127;
    case (mode)
      MODE_INT4: lvl = 8'd7;
      MODE_INT2, MODE_TERN: lvl = 8'd1;
      default: lvl = 8'd127;
    endcase
  end
  assign mag = rdata[15] ? (17'd0 - {1'b1, rdata}) : {1'b0, rdata};

  // Restoring divider, one quotient bit a cycle, remainder against 2m.
  assign trial = {rem, 1'b0} - {8'd0, blk.scale, 1'b0};

  // Clamp, sign and code the quotient; ternary mode codes the sample against fixed thresholds.
  always_comb begin
    qmag = quo;
    code = 8'd0;
    width = 4'd8;
    case (mode)
      MODE_INT8: begin
        if (!rdata[15] && quo > 8'd127) qmag = 8'd127;
        code = rdata[15] ? (8'd0 - qmag) : qmag;
      end
      MODE_INT4: begin
        width = 4'd4;
        if (!rdata[15] && quo > 8'd7) qmag = 8'd7;
        if (rdata[15] && quo > 8'd8) qmag = 8'd8;
        code = rdata[15] ? (8'd8 - qmag) : (qmag + 8'd8);
      end
      MODE_INT2: begin
        width = 4'd2;
        if (!rdata[15] && quo > 8'd1) qmag = 8'd1;
        if (rdata[15] && quo > 8'd2) qmag = 8'd2;
        code = rdata[15] ? (8'd2 - qmag) : (qmag + 8'd2);
      end
      default: begin
        width = 4'd2;
        if (!rdata[15] && rdata > 16'sd128) code = 8'd2;
        else if (rdata[15] && $signed(rdata) < -16'sd128) code = 8'd1;
        else code = 8'd0;
      end
    endcase
  end
  assign acc_new = acc | 8'(code << pos[2:0]);
  assign pos_new = pos + width;
  assign final_s = (idx + 1'b1) == blk.count;
  assign flush = (pos_new >= 4'd8) || final_s;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (blk_valid && !out_valid) state_next = ST_READ;
      ST_READ: state_next = ST_DIV;
      ST_DIV: if (step == 5'd0) state_next = ST_PACK;
      ST_PACK: if (!(flush && out_valid && !out_ready))
        state_next = final_s ? ST_IDLE : ST_READ;
      default: state_next = ST_IDLE;
    endcase
  end

  assign blk_done = (state == ST_PACK) && final_s && !(out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
      acc <= '0;
      pos <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && !(state == ST_PACK && flush)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          acc <= '0;
          pos <= '0;
        end
        ST_READ: begin
          numer <= ({6'd0, mag, 1'b0} * {16'd0, lvl}) + {7'd0, blk.scale};
          rem <= '0;
          step <= 5'd23;
          quo <= '0;
        end
        ST_DIV: begin
          // Shift in the next numerator bit and subtract 2m when it fits.
          if (!trial[25] || (({rem, numer[23]} >= {7'd0, blk.scale, 1'b0}))) begin
            rem <= 25'({rem, numer[23]} - {7'd0, blk.scale, 1'b0});
            quo <= {quo[6:0], 1'b1};
          end else begin
            rem <= {rem[23:0], numer[23]};
            quo <= {quo[6:0], 1'b0};
          end
          numer <= {numer[22:0], 1'b0};
          if (step != 5'd0) step <= step - 1'b1;
        end
        ST_PACK: begin
          if (!(flush && out_valid && !out_ready)) begin
            if (flush) begin
              packed_byte <= acc_new;
              block_scale <= blk.scale[15:0];
              last_byte <= final_s;
              out_valid <= 1'b1;
              acc <= '0;
              pos <= '0;
            end else begin
              acc <= acc_new;
              pos <= pos_new;
            end
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/absmax_block_quantizer_packer_unit.sv
`timescale 1ns / 1ps
// Block absmax quantiser and packer. Samples are taken at one a cycle into a
// 64-entry store while the peak magnitude is tracked; end_of_block or a full
// store closes the block. The block is then coded sample by sample through a
// bit-serial divider: each sample passes through a read, 24 divide steps and a
// pack, and a completed byte waits for the receiver; while a block is being
// coded no new request is taken. quant_mode should change only idle.
module absmax_block_quantizer_packer_unit import abq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               end_of_block,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         packed_byte,
  output logic [15:0]        block_scale,
  output logic               last_byte
);

  logic [1:0] quant_mode;
  logic mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [15:0] mem_data;
  logic blk_valid;
  blk_t blk;
  logic blk_done;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) quant_mode <= MODE_INT8;
    else if (cfg_we) quant_mode <= cfg_wdata;
  end

  abq_front u_front (
    .clk, .rst, .sample, .end_of_block, .in_valid, .in_ready,
    .mem_we, .mem_addr, .mem_data, .blk_valid, .blk, .blk_done
  );

  abq_back u_back (
    .clk, .rst, .quant_mode, .mem_we, .mem_waddr(mem_addr), .mem_wdata(mem_data),
    .blk_valid, .blk, .blk_done, .out_valid, .out_ready,
    .packed_byte, .block_scale, .last_byte
  );

  // The store is never written while a closed block is being coded.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> !mem_we) else $error("store written while busy");
  a_scale_nonzero: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> blk.scale != 17'd0) else $error("zero scale");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    blk_done |-> blk_valid) else $error("done without block");

endmodule

>>> dv/tb_absmax_block_quantizer_packer_unit.sv
`timescale 1ns / 1ps
module tb_absmax_block_quantizer_packer_unit;
  import abq_pkg::*;

  typedef struct {
    logic [7:0]  bits;
    logic [15:0] scale;
    logic        last;
  } byte_exp_t;

  // Scoreboard: keeps its own copy of the block state and predicts the packed bytes.
  class packer_scoreboard;
    logic [15:0] held[64];
    int          held_cnt;
    int          peak;
    mode_t       mode;
    byte_exp_t   bytes_due[$];
    int          errors;

    function new();
      held_cnt = 0;
      peak = 0;
      mode = MODE_INT8;
      errors = 0;
    endfunction

    // Symmetric rounding to L levels, half away from zero, then clamped.
    function int quant(int x, int m, int lvl, int lo, int hi);
      int a;
      int q;
      a = (x < 0) ? -x : x;
      q = (2 * a * lvl + m) / (2 * m);
      if (x < 0) q = -q;
      if (q < lo) q = lo;
      if (q > hi) q = hi;
      return q;
    endfunction

    // Closes the block and queues every byte that it packs into.
    function void close_block();
      int m;
      int acc;
      int pos;
      int x;
      int code;
      int w;
      byte_exp_t e;
      m = (peak == 0) ? 256 : peak;
      acc = 0;
      pos = 0;
      for (int i = 0; i < held_cnt; i++) begin
        x = $signed(held[i]);
        case (mode)
          MODE_INT8: begin
            code = (quant(x, m, 127, -128, 127) + 256) & 8'hff;
            w = 8;
          end
          MODE_INT4: begin
            code = (quant(x, m, 7, -8, 7) + 8) & 4'hf;
            w = 4;
          end
          MODE_INT2: begin
            code = (quant(x, m, 1, -2, 1) + 2) & 2'h3;
            w = 2;
          end
          default: begin
            code = (x > 128) ? 2 : ((x < -128) ? 1 : 0);
            w = 2;
          end
        endcase
        acc |= code << pos;
        pos += w;
        if (pos >= 8 || i == held_cnt - 1) begin
          e.bits = acc[7:0];
          e.scale = m[15:0];
          e.last = (i == held_cnt - 1);
          bytes_due.push_back(e);
          acc = 0;
          pos = 0;
        end
      end
      held_cnt = 0;
      peak = 0;
    endfunction

    // Notes an accepted request.
    function void note_sample(logic signed [15:0] s, logic eob);
      int a;
      a = (s < 0) ? -int'(s) : int'(s);
      held[held_cnt] = s;
      held_cnt++;
      if (a > peak) peak = a;
      if (eob || held_cnt >= BlockLen) close_block();
    endfunction

    // Compares one emitted byte with the oldest prediction.
    function void check_byte(logic [7:0] b, logic [15:0] sc, logic lst);
      byte_exp_t e;
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected byte %h scale %h last %b", $time, b, sc, lst);
        errors++;
        return;
      end
      e = bytes_due.pop_front();
      if (b !== e.bits) begin
        $display("%0t: packed_byte expected %h actual %h", $time, e.bits, b);
        errors++;
      end
      if (sc !== e.scale) begin
        $display("%0t: block_scale expected %h actual %h", $time, e.scale, sc);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] sample;
  logic               end_of_block;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         packed_byte;
  logic [15:0]        block_scale;
  logic               last_byte;

  packer_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int sent;

  absmax_block_quantizer_packer_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .end_of_block(end_of_block), .out_valid(out_valid), .out_ready(out_ready),
    .packed_byte(packed_byte), .block_scale(block_scale), .last_byte(last_byte)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted byte is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_byte(packed_byte, block_scale, last_byte);
  end

  // Offers one request, with a random gap beforehand, and waits for acceptance.
  task automatic send_sample(logic signed [15:0] s, logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    end_of_block <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s, eob);
    sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted byte has arrived and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.bytes_due.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_mode(mode_t m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(4))
      0: return 16'($urandom());
      1: return 16'($urandom_range(1023) - 512);
      2: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
      3: return 16'($urandom_range(266, 246) - ($urandom_range(1) * 512));
      default: return 16'($urandom_range(6) - 3);
    endcase
  endfunction

  // Random blocks: mostly short, some long enough to fill the store.
  task automatic random_phase(int n_items);
    int start;
    int len;
    bit zeros;
    start = sent;
    while (sent - start < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(16, 1);
      zeros = ($urandom_range(11) == 0);
      for (int i = 0; i < len; i++)
        send_sample(zeros ? 16'sd0 : pick_sample(), i == len - 1);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    in_valid = 1'b0;
    sample = 16'sd0;
    end_of_block = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    sent = 0;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes in int8, an all-zero block, partial bytes, ternary thresholds.
    set_mode(MODE_INT8);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
    drain();
    set_mode(MODE_INT4);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    drain();
    set_mode(MODE_INT2);
    send_sample(16'sd256, 1'b0);
    send_sample(-16'sd256, 1'b0);
    send_sample(16'sd128, 1'b0);
    send_sample(-16'sd128, 1'b0);
    send_sample(16'sd384, 1'b1);
    drain();
    set_mode(MODE_TERN);
    send_sample(16'sd128, 1'b0);
    send_sample(-16'sd128, 1'b0);
    send_sample(16'sd129, 1'b0);
    send_sample(-16'sd129, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    drain();

    // Random phases under different flow patterns.
    set_mode(MODE_INT8);
    random_phase(100);
    set_mode(MODE_TERN);
    send_idle_pct = 81;
    random_phase(100);
    set_mode(MODE_INT4);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    random_phase(100);
    set_mode(MODE_INT2);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    random_phase(100);

    // Long receiver hold-off while requests keep coming.
    set_mode(MODE_INT8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 3000;
    random_phase(100);

    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
      $display("absmax_block_quantizer_packer_unit verification clean");
    end else begin
      $display("absmax_block_quantizer_packer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("absmax_block_quantizer_packer_unit verification failed");
    $finish;
  end

endmodule
